// ===== design/tcp_retransmit_history_ring_assert.svh =====
// assertion macros for the retransmit history ring
// no dependencies
`ifndef TCP_RETRANSMIT_HISTORY_RING_ASSERT_SVH
`define TCP_RETRANSMIT_HISTORY_RING_ASSERT_SVH
// implication checked on every rising clock edge, disabled in reset
`define TRH_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define TRH_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== design/trh_pkg.sv =====
// package for the retransmit history ring: types, constants, helpers
// no dependencies
package trh_pkg;

    localparam int unsigned CAPACITY_DEFAULT = 16;
    localparam logic [31:0] RANGE_LIMIT = 32'h4000_0000;
    localparam logic [31:0] COUNT_MAX   = 32'hffff_ffff;

    typedef enum logic [1:0] {
        MODE_ORIGINAL = 2'd0,
        MODE_RETRANSMIT = 2'd1,
        MODE_ACK = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_ACK,
        ST_FINISH,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch input item
        logic scan_clr; // reset walk index
        logic scan_adv; // check one record in scan pass
        logic upd_adv;  // update one record
        logic ack_step; // one acknowledge step
        logic append;   // write original
        logic finish;   // form result
    } trh_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       walk_done;
        logic       rtx_ok;
        logic       ack_done;
        logic       hit_found;
    } trh_status_t;

    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        begin
            d = a - b;
            return d[31];
        end
    endfunction

    function automatic logic range_ok(input logic [31:0] f, input logic [31:0] e);
        logic [31:0] len;
        begin
            len = e - f;
            return (len != 32'd0) && (len <= RANGE_LIMIT);
        end
    endfunction

endpackage

// ===== design/trh_if.sv =====
// valid/ready channel carrying one payload of type parameter
// depends on nothing
interface trh_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/trh_ctrl.sv =====
// controller for the retransmit history ring
// depends on trh_pkg and tcp_retransmit_history_ring_assert.svh
module trh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  trh_pkg::trh_status_t stat,
    output trh_pkg::trh_cmd_t    cmd
);
    trh_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= trh_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trh_pkg::ST_IDLE:
                if (in_valid) state_next = trh_pkg::ST_SCAN;
            trh_pkg::ST_SCAN:
            begin
                priority case (stat.mode)
                    trh_pkg::MODE_ORIGINAL: state_next = trh_pkg::ST_FINISH;
                    trh_pkg::MODE_ACK:      state_next = trh_pkg::ST_ACK;
                    trh_pkg::MODE_RETRANSMIT:
                        if (stat.walk_done)
                            state_next = stat.rtx_ok ? trh_pkg::ST_UPDATE
                                                     : trh_pkg::ST_FINISH;
                    default:
                        if (stat.walk_done || stat.hit_found)
                            state_next = trh_pkg::ST_FINISH;
                endcase
            end
            trh_pkg::ST_UPDATE:
                if (stat.walk_done) state_next = trh_pkg::ST_FINISH;
            trh_pkg::ST_ACK:
                if (stat.ack_done) state_next = trh_pkg::ST_FINISH;
            trh_pkg::ST_FINISH:
                state_next = trh_pkg::ST_OUT;
            trh_pkg::ST_OUT:
                if (out_ready) state_next = trh_pkg::ST_IDLE;
            default:
                state_next = trh_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            trh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            trh_pkg::ST_SCAN:
            begin
                priority case (stat.mode)
                    trh_pkg::MODE_ORIGINAL: cmd.append = 1'b1;
                    trh_pkg::MODE_ACK:      cmd.scan_clr = 1'b1;
                    trh_pkg::MODE_RETRANSMIT:
                    begin
                        cmd.scan_adv = !stat.walk_done;
                        cmd.scan_clr = stat.walk_done;
                    end
                    default:
                        cmd.scan_adv = !stat.walk_done && !stat.hit_found;
                endcase
            end
            trh_pkg::ST_UPDATE: cmd.upd_adv = !stat.walk_done;
            trh_pkg::ST_ACK:    cmd.ack_step = !stat.ack_done;
            trh_pkg::ST_FINISH: cmd.finish = 1'b1;
            trh_pkg::ST_OUT:    out_valid = 1'b1;
            default: ;
        endcase
    end

    `include "tcp_retransmit_history_ring_assert.svh"
    `TRH_ASSERT_IMP(a_no_both, clk, rst_n, in_ready, !out_valid)
    `TRH_ASSERT_NEXT(a_load_scan, clk, rst_n, in_valid && in_ready, state_reg == trh_pkg::ST_SCAN)
    `TRH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

// ===== design/trh_datapath.sv =====
// record store and compare path for the retransmit history ring
// depends on trh_pkg and tcp_retransmit_history_ring_assert.svh
module trh_datapath #(
    parameter int unsigned CAPACITY = trh_pkg::CAPACITY_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  trh_pkg::trh_cmd_t    cmd,
    output trh_pkg::trh_status_t stat,
    input  logic [1:0]           in_mode,
    input  logic [31:0]          in_first,
    input  logic [31:0]          in_end,
    input  logic [31:0]          in_point,
    input  logic [63:0]          in_now,
    output logic                 r_accepted,
    output logic [4:0]           r_updated,
    output logic                 r_hit,
    output logic [4:0]           r_occupancy,
    output logic                 r_valid,
    output logic [31:0]          r_first,
    output logic [31:0]          r_end,
    output logic [31:0]          r_retransmits,
    output logic [63:0]          r_first_sent,
    output logic [63:0]          r_last_sent
);
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // record store, valid bits give the zero reset value
    logic [31:0] first_mem [CAPACITY];
    logic [31:0] end_mem   [CAPACITY];
    logic [63:0] fs_mem    [CAPACITY];
    logic [63:0] ls_mem    [CAPACITY];
    logic [31:0] rt_mem    [CAPACITY];
    logic [CAPACITY-1:0] vld_reg;

    logic [IW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [1:0]  mode_reg;
    logic [31:0] first_reg, end_reg, point_reg;
    logic [63:0] now_reg;
    logic found_reg, ok_reg, hit_reg, acc_reg;
    logic [4:0] upd_reg;

    function automatic logic [IW-1:0] wrap(input logic [CW:0] v);
        logic [CW:0] r;
        begin
            r = (v >= (CW+1)'(CAPACITY)) ? v - (CW+1)'(CAPACITY) : v;
            return r[IW-1:0];
        end
    endfunction

    logic [IW-1:0] slot, tail, nhead;
    logic [31:0] s_first, s_end, s_rt, h_first, h_end;
    logic [63:0] s_ls, t_fs;
    logic [31:0] t_end;
    logic ovl, walk_done, rok, h_pop, app_ok, ack_trim;

    always_comb
    begin
        slot  = wrap({1'b0, head_reg} + {1'b0, idx_reg});
        tail  = wrap({1'b0, head_reg} + {1'b0, count_reg} - (CW+1)'(1));
        nhead = wrap({1'b0, head_reg} + (CW+1)'(1));
        s_first = vld_reg[slot] ? first_mem[slot] : '0;
        s_end   = vld_reg[slot] ? end_mem[slot] : '0;
        s_ls    = vld_reg[slot] ? ls_mem[slot] : '0;
        s_rt    = vld_reg[slot] ? rt_mem[slot] : '0;
        t_end   = vld_reg[tail] ? end_mem[tail] : '0;
        t_fs    = vld_reg[tail] ? fs_mem[tail] : '0;
        h_first = vld_reg[head_reg] ? first_mem[head_reg] : '0;
        h_end   = vld_reg[head_reg] ? end_mem[head_reg] : '0;
        ovl = trh_pkg::seq_before(first_reg, s_end) && trh_pkg::seq_before(s_first, end_reg);
        walk_done = (idx_reg == count_reg);
        rok = trh_pkg::range_ok(first_reg, end_reg);
        h_pop = (h_end == point_reg) || trh_pkg::seq_before(h_end, point_reg);
        // original admitted: room, legal range, contiguous and not earlier
        app_ok = (count_reg != CW'(CAPACITY)) && rok
            && ((count_reg == '0) || (t_end == first_reg && now_reg >= t_fs));
        // head record moved up to the acknowledgment
        ack_trim = (mode_reg == trh_pkg::MODE_ACK) && (count_reg != '0)
            && trh_pkg::seq_before(h_first, point_reg);
    end

    assign stat.mode = mode_reg;
    assign stat.walk_done = walk_done;
    assign stat.rtx_ok = rok && found_reg && ok_reg;
    assign stat.ack_done = (count_reg == '0) || !h_pop;
    assign stat.hit_found = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            ok_reg <= 1'b1;
            hit_reg <= 1'b0;
            acc_reg <= 1'b0;
            upd_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
                ok_reg <= 1'b1;
                hit_reg <= 1'b0;
                acc_reg <= 1'b0;
                upd_reg <= '0;
            end
            if (cmd.scan_clr)
                idx_reg <= '0;
            if (cmd.scan_adv)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (ovl)
                begin
                    found_reg <= 1'b1;
                    if (now_reg < s_ls) ok_reg <= 1'b0;
                end
                if (mode_reg == trh_pkg::MODE_QUERY
                    && !trh_pkg::seq_before(point_reg, s_first)
                    && trh_pkg::seq_before(point_reg, s_end))
                    hit_reg <= 1'b1;
            end
            if (cmd.upd_adv)
            begin
                idx_reg <= idx_reg + 1'b1;
                acc_reg <= 1'b1;
                if (ovl)
                begin
                    upd_reg <= upd_reg + 1'b1;
                    vld_reg[slot] <= 1'b1;
                end
            end
            if (cmd.append && app_ok)
            begin
                acc_reg <= 1'b1;
                vld_reg[wrap({1'b0, head_reg} + {1'b0, count_reg})] <= 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.ack_step)
            begin
                vld_reg[head_reg] <= 1'b0;
                count_reg <= count_reg - 1'b1;
                head_reg <= (count_reg == CW'(1)) ? '0 : nhead;
            end
            if (cmd.finish && ack_trim)
                vld_reg[head_reg] <= 1'b1;
        end
    end

    // payload storage and result registers
    always_ff @(posedge clk)
    begin
        logic [IW-1:0] ws;
        ws = wrap({1'b0, head_reg} + {1'b0, count_reg});
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            first_reg <= in_first;
            end_reg <= in_end;
            point_reg <= in_point;
            now_reg <= in_now;
        end
        if (cmd.upd_adv && ovl)
        begin
            ls_mem[slot] <= now_reg;
            rt_mem[slot] <= (s_rt == trh_pkg::COUNT_MAX) ? s_rt : s_rt + 1'b1;
            first_mem[slot] <= s_first;
            end_mem[slot] <= s_end;
            fs_mem[slot] <= vld_reg[slot] ? fs_mem[slot] : '0;
        end
        if (cmd.append && app_ok)
        begin
            first_mem[ws] <= first_reg;
            end_mem[ws] <= end_reg;
            fs_mem[ws] <= now_reg;
            ls_mem[ws] <= now_reg;
            rt_mem[ws] <= '0;
        end
        if (cmd.finish && ack_trim)
        begin
            first_mem[head_reg] <= point_reg;
            end_mem[head_reg] <= h_end;
            fs_mem[head_reg] <= vld_reg[head_reg] ? fs_mem[head_reg] : '0;
            ls_mem[head_reg] <= vld_reg[head_reg] ? ls_mem[head_reg] : '0;
            rt_mem[head_reg] <= vld_reg[head_reg] ? rt_mem[head_reg] : '0;
        end
        if (cmd.finish)
        begin
            r_accepted <= acc_reg;
            r_updated <= upd_reg;
            r_hit <= hit_reg;
            r_occupancy <= 5'(count_reg);
            r_valid <= (count_reg != '0);
            r_first <= (count_reg == '0) ? '0 : (ack_trim ? point_reg : h_first);
            r_end <= (count_reg != '0) ? h_end : '0;
            r_retransmits <= (count_reg != '0 && vld_reg[head_reg]) ? rt_mem[head_reg] : '0;
            r_first_sent <= (count_reg != '0 && vld_reg[head_reg]) ? fs_mem[head_reg] : '0;
            r_last_sent <= (count_reg != '0 && vld_reg[head_reg]) ? ls_mem[head_reg] : '0;
        end
    end

    `include "tcp_retransmit_history_ring_assert.svh"
    `TRH_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `TRH_ASSERT_IMP(a_empty_head, clk, rst_n, count_reg == '0, head_reg == '0)
    `TRH_ASSERT_NEXT(a_pop_one, clk, rst_n, cmd.ack_step, count_reg == $past(count_reg) - 1'b1)
endmodule

// ===== design/tcp_retransmit_history_ring.sv =====
// top level of the tcp retransmit history ring: controller plus datapath
// one compare path walks the ring twice for a retransmission, a scan pass then an
// update pass; an ack pops one record per step, and a query walks the ring until
// a hit or the end of the held records
// throughput: one item at a time, next item taken after the result transfer completes
// reset: asynchronous active low; store emptied through per-slot valid bits at once
module tcp_retransmit_history_ring #(
    parameter int unsigned CAPACITY = trh_pkg::CAPACITY_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    trh_if.sink   in_ch,
    trh_if.source out_ch
);
    trh_pkg::trh_cmd_t    cmd;
    trh_pkg::trh_status_t stat;

    // controller sequences scan, update and acknowledge passes
    trh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath holds records and the registered result
    trh_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_mode       (in_ch.data.mode),
        .in_first      (in_ch.data.range_first),
        .in_end        (in_ch.data.range_end),
        .in_point      (in_ch.data.point_sequence),
        .in_now        (in_ch.data.now_time),
        .r_accepted    (out_ch.data.accepted),
        .r_updated     (out_ch.data.updated_count),
        .r_hit         (out_ch.data.hit),
        .r_occupancy   (out_ch.data.occupancy),
        .r_valid       (out_ch.data.oldest_valid),
        .r_first       (out_ch.data.oldest_first),
        .r_end         (out_ch.data.oldest_end),
        .r_retransmits (out_ch.data.oldest_retransmits),
        .r_first_sent  (out_ch.data.oldest_first_sent),
        .r_last_sent   (out_ch.data.oldest_last_sent)
    );
endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the tcp retransmit history ring
// depends on trh_pkg, trh_if and the tcp_retransmit_history_ring top level
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned RING_DEPTH = trh_pkg::CAPACITY_DEFAULT;
    localparam int unsigned RANDOM_ITEMS = 530;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned MAX_REPORTS = 10;

    // one segment event going into the ring
    typedef struct packed {
        trh_pkg::mode_t mode;
        logic [31:0]    range_first;
        logic [31:0]    range_end;
        logic [31:0]    point_sequence;
        logic [63:0]    now_time;
    } ring_item_t;

    // ring status returned for every segment event
    typedef struct packed {
        logic        accepted;
        logic [4:0]  updated_count;
        logic        hit;
        logic [4:0]  occupancy;
        logic        oldest_valid;
        logic [31:0] oldest_first;
        logic [31:0] oldest_end;
        logic [31:0] oldest_retransmits;
        logic [63:0] oldest_first_sent;
        logic [63:0] oldest_last_sent;
    } ring_status_t;

    // directed row: the status is typed in only where has_status is set
    typedef struct packed {
        ring_item_t   item;
        logic         has_status;
        ring_status_t status;
    } directed_row_t;

    logic clk;
    logic rst_n;

    trh_if #(.payload_t(ring_item_t))   in_ch ();
    trh_if #(.payload_t(ring_status_t)) out_ch ();

    tcp_retransmit_history_ring uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // shadow copy of the ring
    logic [31:0] sh_first [RING_DEPTH];
    logic [31:0] sh_end [RING_DEPTH];
    logic [63:0] sh_first_sent [RING_DEPTH];
    logic [63:0] sh_last_sent [RING_DEPTH];
    logic [31:0] sh_retx [RING_DEPTH];
    int unsigned sh_head;
    int unsigned sh_count;

    ring_status_t pending_status [$];
    int unsigned  mismatch_count;
    int unsigned  quiet_cycles;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    logic [63:0]  clock_now;
    directed_row_t directed_rows [$];

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // serial-number order: a comes before b
    function automatic logic precedes(logic [31:0] a, logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    function automatic logic span_legal(logic [31:0] f, logic [31:0] e);
        logic [31:0] len;
        len = e - f;
        return (len != 32'd0) && (len <= 32'h4000_0000);
    endfunction

    function automatic int unsigned ring_slot(int unsigned logical);
        return (sh_head + logical) % RING_DEPTH;
    endfunction

    function automatic void wipe_slot(int unsigned s);
        sh_first[s] = '0;
        sh_end[s] = '0;
        sh_first_sent[s] = '0;
        sh_last_sent[s] = '0;
        sh_retx[s] = '0;
    endfunction

    // applies one event to the shadow ring and returns the status it yields
    function automatic ring_status_t apply_segment_event(ring_item_t it);
        ring_status_t st;
        logic         admit;
        logic         seen;
        int unsigned  s;
        int unsigned  tail;
        st = '0;
        case (it.mode)
            trh_pkg::MODE_ORIGINAL:
            begin
                if (sh_count < RING_DEPTH && span_legal(it.range_first, it.range_end))
                begin
                    admit = 1'b1;
                    if (sh_count != 0)
                    begin
                        tail = ring_slot(sh_count - 1);
                        admit = (sh_end[tail] == it.range_first)
                            && (it.now_time >= sh_first_sent[tail]);
                    end
                    if (admit)
                    begin
                        s = ring_slot(sh_count);
                        sh_first[s] = it.range_first;
                        sh_end[s] = it.range_end;
                        sh_first_sent[s] = it.now_time;
                        sh_last_sent[s] = it.now_time;
                        sh_retx[s] = '0;
                        sh_count++;
                        st.accepted = 1'b1;
                    end
                end
            end
            trh_pkg::MODE_RETRANSMIT:
            begin
                if (span_legal(it.range_first, it.range_end))
                begin
                    admit = 1'b1;
                    seen = 1'b0;
                    for (int unsigned i = 0; i < sh_count; i++)
                    begin
                        s = ring_slot(i);
                        if (precedes(it.range_first, sh_end[s])
                            && precedes(sh_first[s], it.range_end))
                        begin
                            seen = 1'b1;
                            if (it.now_time < sh_last_sent[s])
                                admit = 1'b0;
                        end
                    end
                    if (admit && seen)
                    begin
                        for (int unsigned i = 0; i < sh_count; i++)
                        begin
                            s = ring_slot(i);
                            if (precedes(it.range_first, sh_end[s])
                                && precedes(sh_first[s], it.range_end))
                            begin
                                if (sh_retx[s] != 32'hffff_ffff)
                                    sh_retx[s]++;
                                sh_last_sent[s] = it.now_time;
                                st.updated_count++;
                            end
                        end
                        st.accepted = 1'b1;
                    end
                end
            end
            trh_pkg::MODE_ACK:
            begin
                while (sh_count != 0)
                begin
                    s = sh_head;
                    if (sh_end[s] == it.point_sequence || precedes(sh_end[s], it.point_sequence))
                    begin
                        wipe_slot(s);
                        sh_head = (sh_head + 1) % RING_DEPTH;
                        sh_count--;
                    end
                    else
                    begin
                        if (precedes(sh_first[s], it.point_sequence))
                            sh_first[s] = it.point_sequence;
                        break;
                    end
                end
                if (sh_count == 0)
                    sh_head = 0;
            end
            default:
            begin
                for (int unsigned i = 0; i < sh_count; i++)
                begin
                    s = ring_slot(i);
                    if (!precedes(it.point_sequence, sh_first[s])
                        && precedes(it.point_sequence, sh_end[s]))
                    begin
                        st.hit = 1'b1;
                        break;
                    end
                end
            end
        endcase
        st.occupancy = sh_count[4:0];
        if (sh_count != 0)
        begin
            s = sh_head;
            st.oldest_valid = 1'b1;
            st.oldest_first = sh_first[s];
            st.oldest_end = sh_end[s];
            st.oldest_retransmits = sh_retx[s];
            st.oldest_first_sent = sh_first_sent[s];
            st.oldest_last_sent = sh_last_sent[s];
        end
        return st;
    endfunction

    function automatic logic [63:0] advance_clock(int unsigned max_step);
        clock_now = clock_now + 64'(max_step == 0 ? 0 : $urandom_range(0, max_step));
        return clock_now;
    endfunction

    // random event, mostly well formed against the current ring contents
    function automatic ring_item_t pick_segment_event();
        ring_item_t  it;
        int unsigned pick;
        int unsigned s;
        logic [31:0] len;
        it.mode = trh_pkg::mode_t'($urandom_range(0, 3));
        it.range_first = $urandom;
        it.range_end = $urandom;
        it.point_sequence = $urandom;
        it.now_time = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        s = (sh_count != 0) ? ring_slot($urandom_range(0, sh_count - 1)) : 0;
        len = ($urandom_range(0, 9) == 0) ? 32'h4000_0000 - $urandom_range(0, 2)
                                           : 32'($urandom_range(1, 2000));
        if (pick < 40)
        begin
            // append at the tail
            it.mode = trh_pkg::MODE_ORIGINAL;
            if (sh_count != 0)
                it.range_first = sh_end[ring_slot(sh_count - 1)];
            it.range_end = it.range_first + len;
            it.now_time = advance_clock(500);
        end
        else if (pick < 60)
        begin
            it.mode = trh_pkg::MODE_RETRANSMIT;
            if (sh_count != 0)
            begin
                it.range_first = sh_first[s] - $urandom_range(0, 100);
                it.range_end = sh_end[s] + $urandom_range(0, 3000);
            end
            else
                it.range_end = it.range_first + len;
            it.now_time = advance_clock(500);
            // stale send time now and then
            if ($urandom_range(0, 7) == 0)
                it.now_time = clock_now - $urandom_range(1, 1000);
        end
        else if (pick < 75)
        begin
            it.mode = trh_pkg::MODE_ACK;
            if (sh_count != 0)
                it.point_sequence = ($urandom_range(0, 1) == 0) ? sh_end[s]
                    : sh_first[s] + $urandom_range(0, 1500);
        end
        else if (pick < 90)
        begin
            it.mode = trh_pkg::MODE_QUERY;
            if (sh_count != 0)
                it.point_sequence = sh_first[s] + $urandom_range(0, 1) - $urandom_range(0, 1)
                    + (($urandom_range(0, 1) == 0) ? 32'd0 : sh_end[s] - sh_first[s]);
        end
        else if ($urandom_range(0, 1) == 0)
            it.now_time = advance_clock(100);
        return it;
    endfunction

    function automatic void check_status(ring_status_t got);
        ring_status_t want;
        string        bad;
        if (pending_status.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected status transfer %h", got);
            return;
        end
        want = pending_status.pop_front();
        bad = "";
        if (got.accepted !== want.accepted) bad = {bad, " accepted"};
        if (got.updated_count !== want.updated_count) bad = {bad, " updated_count"};
        if (got.hit !== want.hit) bad = {bad, " hit"};
        if (got.occupancy !== want.occupancy) bad = {bad, " occupancy"};
        if (got.oldest_valid !== want.oldest_valid) bad = {bad, " oldest_valid"};
        if (got.oldest_first !== want.oldest_first) bad = {bad, " oldest_first"};
        if (got.oldest_end !== want.oldest_end) bad = {bad, " oldest_end"};
        if (got.oldest_retransmits !== want.oldest_retransmits) bad = {bad, " oldest_retransmits"};
        if (got.oldest_first_sent !== want.oldest_first_sent) bad = {bad, " oldest_first_sent"};
        if (got.oldest_last_sent !== want.oldest_last_sent) bad = {bad, " oldest_last_sent"};
        if (bad != "")
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("status mismatch in%s: expected %h actual %h", bad, want, got);
        end
    endfunction

    // drive one event and wait for its transfer; the model is updated at that edge
    task automatic drive_segment_event(ring_item_t it, logic typed, ring_status_t typed_st);
        ring_status_t st;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        st = apply_segment_event(it);
        pending_status.insert(pending_status.size(), typed ? typed_st : st);
        @(negedge clk);
    endtask

    function automatic void add_row(trh_pkg::mode_t m, logic [31:0] f, logic [31:0] e,
                                    logic [31:0] p, logic [63:0] t);
        directed_row_t r;
        r = '0;
        r.item = '{m, f, e, p, t};
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // same as add_row, with the status written out
    function automatic void add_row_status(trh_pkg::mode_t m, logic [31:0] f, logic [31:0] e,
                                           logic [31:0] p, logic [63:0] t, ring_status_t st);
        add_row(m, f, e, p, t);
        directed_rows[$].has_status = 1'b1;
        directed_rows[$].status = st;
    endfunction

    // receiver: stalls at the chosen rate, ready changes at the falling edge
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // status checker and watchdog on the rising edge
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
            check_status(out_ch.data);
        if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL tcp_retransmit_history_ring");
            $finish;
        end
    end

    initial
    begin
        ring_status_t st;
        int unsigned  phase;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        mismatch_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        clock_now = 64'd1000;
        sh_head = 0;
        sh_count = 0;
        for (int unsigned i = 0; i < RING_DEPTH; i++)
            wipe_slot(i);

        // empty ring reports all zero for queries, acks, rejected appends and a rejected retransmission
        add_row_status(trh_pkg::MODE_QUERY, 32'd0, 32'd0, 32'd0, 64'd0, '0);
        add_row_status(trh_pkg::MODE_ACK, 32'd0, 32'd0, 32'hffff_ffff, 64'd0, '0);
        add_row_status(trh_pkg::MODE_ORIGINAL, 32'd5, 32'd5, 32'd0, 64'd0, '0);
        add_row_status(trh_pkg::MODE_ORIGINAL, 32'd0, 32'h4000_0001, 32'd0, 64'd0, '0);
        add_row_status(trh_pkg::MODE_RETRANSMIT, 32'd0, 32'd10, 32'd0, 64'd10, '0);
        // longest legal range, wrapping past zero
        st = '0;
        st.accepted = 1'b1;
        st.occupancy = 5'd1;
        st.oldest_valid = 1'b1;
        st.oldest_first = 32'hffff_fff0;
        st.oldest_end = 32'h3fff_fff0;
        st.oldest_first_sent = 64'd100;
        st.oldest_last_sent = 64'd100;
        add_row_status(trh_pkg::MODE_ORIGINAL, 32'hffff_fff0, 32'h3fff_fff0, 32'd0, 64'd100, st);
        // earlier time and a gap in sequence are refused, then a contiguous append is taken
        add_row(trh_pkg::MODE_ORIGINAL, 32'h3fff_fff0, 32'h4000_0000, 32'd0, 64'd50);
        add_row(trh_pkg::MODE_ORIGINAL, 32'h0001_2345, 32'h0001_3345, 32'd0, 64'd200);
        add_row(trh_pkg::MODE_ORIGINAL, 32'h3fff_fff0, 32'h4000_0010, 32'd0, 64'd100);
        // retransmission: no overlap, overlap of the newer record, back in time, max time
        add_row(trh_pkg::MODE_RETRANSMIT, 32'h8000_0000, 32'h8000_0010, 32'd0, 64'd300);
        add_row(trh_pkg::MODE_RETRANSMIT, 32'h3fff_fff8, 32'h4000_0004, 32'd0, 64'd300);
        add_row(trh_pkg::MODE_RETRANSMIT, 32'h3fff_fff8, 32'h4000_0004, 32'd0, 64'd299);
        add_row(trh_pkg::MODE_RETRANSMIT, 32'h0000_0000, 32'h0000_0001, 32'd0,
                64'hffff_ffff_ffff_ffff);
        // query at the first sequence, at the end, just before
        add_row(trh_pkg::MODE_QUERY, 32'd0, 32'd0, 32'hffff_fff0, 64'd0);
        add_row(trh_pkg::MODE_QUERY, 32'd0, 32'd0, 32'h4000_0010, 64'd0);
        add_row(trh_pkg::MODE_QUERY, 32'd0, 32'd0, 32'hffff_ffef, 64'd0);
        // ack that trims the head, one behind it, then one covering all
        add_row(trh_pkg::MODE_ACK, 32'd0, 32'd0, 32'h0000_0010, 64'd0);
        add_row(trh_pkg::MODE_ACK, 32'd0, 32'd0, 32'hffff_fff0, 64'd0);
        add_row_status(trh_pkg::MODE_ACK, 32'd0, 32'd0, 32'h4000_0010, 64'd0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            drive_segment_event(directed_rows[i].item, directed_rows[i].has_status,
                                directed_rows[i].status);

        // random part in four phases of sender idling and receiver stalls
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            phase = (n * 4) / RANDOM_ITEMS;
            send_idle_pct = (phase == 1) ? 80 : (phase == 3) ? 11 : 0;
            recv_stall_pct = (phase == 2) ? 80 : (phase == 3) ? 11 : 0;
            drive_segment_event(pick_segment_event(), 1'b0, '0);
        end
        in_ch.valid = 1'b0;

        wait (pending_status.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS tcp_retransmit_history_ring");
        else
            $display("FAIL tcp_retransmit_history_ring");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/trh_pkg.sv
design/trh_if.sv
design/trh_ctrl.sv
design/trh_datapath.sv
design/tcp_retransmit_history_ring.sv
verif/testbench.sv
